>>> rtl/assert_macros.svh
// Assertion macros shared by the tracker RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk_i, off while in reset.
`define AET_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// Same-cycle implication.
`define AET_ASSERT_IMP(lbl, ante, cons) \
  `AET_ASSERT(lbl, (ante) |-> (cons))

// Next-cycle implication.
`define AET_ASSERT_NXT(lbl, ante, cons) \
  `AET_ASSERT(lbl, (ante) |=> (cons))

`endif

>>> rtl/aet_pkg.sv
// Package for the absolute encoder angle tracker: widths, bands, config codes
// and the tracker stage record. No dependencies.
`default_nettype none

package aet_pkg;

  localparam int ANGLE_W       = 14;
  localparam int PP_W          = 7;
  localparam int TC_W          = 32;
  localparam int EXT_W         = 47;
  localparam int DELTA_W       = 32;
  localparam int IN_TDATA_W    = 16;
  localparam int OUT_FIELDS_W  = 3 * ANGLE_W + TC_W + EXT_W + DELTA_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

  // History ring depth and pointer width (at least one bit).
  localparam int HISTORY_DEPTH = 10;
  localparam int HIST_PTR_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  // Emulated quadrature bands, in counts.
  localparam logic [ANGLE_W-1:0] BAND_A_END   = ANGLE_W'(4096);
  localparam logic [ANGLE_W-1:0] BAND_B_START = ANGLE_W'(2048);
  localparam logic [ANGLE_W-1:0] BAND_B_END   = ANGLE_W'(6144);

  // Config port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = ANGLE_W;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_OFFSET = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_POLE_PAIRS   = CFG_IDX_W'(1);
  localparam logic [PP_W-1:0]      POLE_PAIRS_RST   = PP_W'(1);

  // One sample after angle and turn tracking.
  typedef struct packed {
    logic [ANGLE_W-1:0]    raw;
    logic [ANGLE_W-1:0]    joint;
    logic [TC_W-1:0]       tc;
    logic signed [EXT_W-1:0] ext;
  } trk_t;

endpackage

`default_nettype wire

>>> rtl/absolute_encoder_angle_tracker.sv
// Top level of the absolute encoder angle tracker.
// Depends on aet_pkg, aet_turn_track, aet_hist_mem and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// One sensor word in, one result beat out, one beat per clock sustained
// without back-pressure. The low 14 bits of the word are the angle in
// 1/16384 turn. Accept cycle: band decode (A below 4096, B in 2048..6143)
// steps the signed turn counter, the extended position turn*16384 + raw -
// offset is formed and the history ring entry from HISTORY_DEPTH samples
// back is read from a registered synchronous memory. Middle stage: rotor
// angle (joint * pole pairs, 14x7 multiply) and delta against the stored
// position saturated to 32 bits land in the output register, and the new
// position is written back into the same ring entry. A stalled output
// beat does not block the next input beat while the middle stage is free.
// The ring reads as zero until each entry is written after reset (valid
// bit per entry, no clearing pass). The user writes angle_offset (index 0)
// and pole_pairs (index 1) on cfg_we_i only while idle; not enforced here.
module absolute_encoder_angle_tracker
  import aet_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // config write port
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  // sensor stream
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // raw_word
  // result stream
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // raw_angle, joint_angle, rotor_angle, turn_count, extended_position,
  // position_delta, zero pad
  output      logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [ANGLE_W-1:0] offset_q;
  logic [PP_W-1:0]    pp_q;

  logic in_acc, s1_adv;
  trk_t trk;

  // middle stage
  logic s1_valid_q;
  trk_t s1_q;

  // output stage
  logic                    m_valid_q;
  logic [ANGLE_W-1:0]      out_raw_q, out_joint_q, out_rotor_q;
  logic [TC_W-1:0]         out_tc_q;
  logic signed [EXT_W-1:0] out_ext_q;
  logic [DELTA_W-1:0]      out_delta_q;

  logic signed [EXT_W-1:0] old_ext;
  logic signed [EXT_W:0]   dfull;
  logic [DELTA_W-1:0]      delta_sat;
  logic [ANGLE_W+PP_W-1:0] rot_prod;
  logic                    hi_same;

  // ---- config ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      pp_q     <= POLE_PAIRS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ANGLE_OFFSET: offset_q <= cfg_data_i[ANGLE_W-1:0];
        CFG_POLE_PAIRS:   pp_q     <= cfg_data_i[PP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- handshake: middle stage moves when the output register frees ----
  assign s1_adv        = !m_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  aet_turn_track u_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (in_acc),
    .raw_i    (s_axis_tdata[ANGLE_W-1:0]),
    .offset_i (offset_q),
    .trk_o    (trk)
  );

  aet_hist_mem u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .wr_en_i   (s1_valid_q && s1_adv),
    .wr_data_i (s1_q.ext),
    .old_o     (old_ext)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= trk;
    end
  end

  // ---- delta and rotor ----
  assign dfull   = {s1_q.ext[EXT_W-1], s1_q.ext} - {old_ext[EXT_W-1], old_ext};
  // fits in 32 bits when bits 47..31 all agree
  assign hi_same = (dfull[EXT_W:DELTA_W-1] == {(EXT_W-DELTA_W+2){dfull[EXT_W]}});

  always_comb begin
    if (hi_same) begin
      delta_sat = dfull[DELTA_W-1:0];
    end else if (dfull[EXT_W]) begin
      delta_sat = {1'b1, {(DELTA_W-1){1'b0}}};
    end else begin
      delta_sat = {1'b0, {(DELTA_W-1){1'b1}}};
    end
  end

  assign rot_prod = s1_q.joint * pp_q;

  // ---- output register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_adv) begin
      m_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_raw_q   <= s1_q.raw;
      out_joint_q <= s1_q.joint;
      out_rotor_q <= rot_prod[ANGLE_W-1:0];
      out_tc_q    <= s1_q.tc;
      out_ext_q   <= s1_q.ext;
      out_delta_q <= delta_sat;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_delta_q, out_ext_q, out_tc_q,
                          out_rotor_q, out_joint_q, out_raw_q};

  // full pipe with a stalled output must refuse input
  `AET_ASSERT_IMP(a_full_stall, s1_valid_q && m_valid_q && !m_axis_tready, !s_axis_tready)
  // an output beat only appears from a held middle-stage sample
  `AET_ASSERT_IMP(a_out_src, $rose(m_valid_q), $past(s1_valid_q))

endmodule

`default_nettype wire

>>> rtl/aet_turn_track.sv
// Turn tracker: quadrature emulation, turn counter, joint angle and
// extended position for the sample being accepted. Uses aet_pkg.
`default_nettype none
`include "assert_macros.svh"

module aet_turn_track
  import aet_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               acc_i,
  input  wire logic [ANGLE_W-1:0] raw_i,
  input  wire logic [ANGLE_W-1:0] offset_i,
  output      trk_t               trk_o
);

  logic [TC_W-1:0]  tc_q, tc_d;
  logic             prev_a_q;
  logic             a, b;
  logic [ANGLE_W:0] diff;

  assign a = (raw_i < BAND_A_END);
  assign b = (raw_i >= BAND_B_START) && (raw_i < BAND_B_END);

  always_comb begin
    tc_d = tc_q;
    if (!prev_a_q && a && !b) begin
      tc_d = tc_q + TC_W'(1);
    end else if (prev_a_q && !a && !b) begin
      tc_d = tc_q - TC_W'(1);
    end
  end

  // raw - offset as 15-bit signed; low bits are the joint angle
  assign diff = {1'b0, raw_i} - {1'b0, offset_i};

  always_comb begin
    trk_o.raw   = raw_i;
    trk_o.joint = diff[ANGLE_W-1:0];
    trk_o.tc    = tc_d;
    trk_o.ext   = $signed({tc_d[TC_W-1], tc_d, {ANGLE_W{1'b0}}})
                + $signed({{(EXT_W-ANGLE_W-1){diff[ANGLE_W]}}, diff});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q     <= '0;
      prev_a_q <= 1'b0;
    end else if (acc_i) begin
      tc_q     <= tc_d;
      prev_a_q <= a;
    end
  end

  `AET_ASSERT_NXT(a_tc_idle_hold, !acc_i, $stable(tc_q) && $stable(prev_a_q))

endmodule

`default_nettype wire

>>> rtl/aet_hist_mem.sv
// History ring of extended positions: synchronous memory with registered read,
// per-entry valid bits for the zero reset, same-entry forwarding. Uses aet_pkg.
`default_nettype none
`include "assert_macros.svh"

module aet_hist_mem
  import aet_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    rd_en_i,
  input  wire logic                    wr_en_i,
  input  wire logic signed [EXT_W-1:0] wr_data_i,
  output      logic signed [EXT_W-1:0] old_o
);

  logic signed [EXT_W-1:0] mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] vld_q;
  logic [HIST_PTR_W-1:0]   rd_ptr_q, wr_ptr_q;
  logic signed [EXT_W-1:0] rdata_q, fwd_data_q;
  logic                    rvalid_q, fwd_q;

  function automatic logic [HIST_PTR_W-1:0] ptr_next(input logic [HIST_PTR_W-1:0] p);
    logic [HIST_PTR_W-1:0] r;
    if (p == HIST_PTR_W'(HISTORY_DEPTH - 1)) r = '0;
    else r = p + HIST_PTR_W'(1);
    return r;
  endfunction

  // memory array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_ptr_q] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_ptr_q];
    end
    if (rd_en_i) begin
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      rvalid_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_ptr_q] <= 1'b1;
        wr_ptr_q        <= ptr_next(wr_ptr_q);
      end
      if (rd_en_i) begin
        rvalid_q <= vld_q[rd_ptr_q];
        fwd_q    <= wr_en_i && (wr_ptr_q == rd_ptr_q);
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
    end
  end

  assign old_o = fwd_q    ? fwd_data_q :
                 rvalid_q ? rdata_q    : '0;

  // at most one sample sits between read and write-back
  `AET_ASSERT(a_ptr_gap, (rd_ptr_q == wr_ptr_q) || (rd_ptr_q == ptr_next(wr_ptr_q)))

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking bench for absolute_encoder_angle_tracker: stream stimulus, config
// writes, a cycle-free predictor of the tracker and a beat-by-beat result check.
// Depends on aet_pkg and the tracker RTL.
module tb;
  import aet_pkg::*;

  localparam int QUIET_LIMIT  = 5000;  // cycles with no beat on either side
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int SETTLE       = 4;     // pipeline is two deep, keep a margin
  localparam int PHASE_N      = 6;
  localparam int PHASE_ITEMS  = 125;
  localparam int SWEEP_N      = 21;
  localparam int REPORT_MAX   = 10;

  // One result beat, laid out as on m_axis_tdata (raw_angle in the low bits).
  typedef struct packed {
    logic signed [DELTA_W-1:0] delta;
    logic signed [EXT_W-1:0]   pos;
    logic [TC_W-1:0]           turns;
    logic [ANGLE_W-1:0]        rotor;
    logic [ANGLE_W-1:0]        joint;
    logic [ANGLE_W-1:0]        raw;
  } track_t;

  // Directed sweep row; rows with typed_in set carry a hand-written result.
  typedef struct packed {
    logic [IN_TDATA_W-1:0] word;
    logic                  typed_in;
    track_t                want;
  } sweep_row_t;

  localparam track_t NO_RESULT = '0;

  // Rows 0..2 run right after reset (offset 0, one pole pair): entering band A
  // below 2048 from reset counts a turn up, 16383 leaves A outside B and
  // counts it down, and the top two word bits are ignored.
  localparam sweep_row_t SWEEP_ROWS [SWEEP_N] = '{
    '{word: 16'h0000, typed_in: 1'b1,
      want: '{raw: 14'd0, joint: 14'd0, rotor: 14'd0, turns: 32'd1,
              pos: 47'sd16384, delta: 32'sd16384}},
    '{word: 16'hFFFF, typed_in: 1'b1,
      want: '{raw: 14'd16383, joint: 14'd16383, rotor: 14'd16383, turns: 32'd0,
              pos: 47'sd16383, delta: 32'sd16383}},
    '{word: 16'hC000, typed_in: 1'b1,
      want: '{raw: 14'd0, joint: 14'd0, rotor: 14'd0, turns: 32'd1,
              pos: 47'sd16384, delta: 32'sd16384}},
    // band edges: 2047/2048 (B opens), 4095/4096 (A closes), 6143/6144 (B closes)
    '{word: 16'h07FF, typed_in: 1'b0, want: NO_RESULT},
    '{word: 16'h0800, typed_in: 1'b0, want: NO_RESULT},
    '{word: 16'h0FFF, typed_in: 1'b0, want: NO_RESULT},
    '{word: 16'h1000, typed_in: 1'b0, want: NO_RESULT},
    '{word: 16'h17FF, typed_in: 1'b0, want: NO_RESULT},
    '{word: 16'h1800, typed_in: 1'b0, want: NO_RESULT},
    '{word: 16'h0000, typed_in: 1'b0, want: NO_RESULT},  // A rises, B low
    '{word: 16'h1FFF, typed_in: 1'b0, want: NO_RESULT},  // A falls, B low
    '{word: 16'h3FFF, typed_in: 1'b0, want: NO_RESULT},
    '{word: 16'h4000, typed_in: 1'b0, want: NO_RESULT},
    '{word: 16'h8000, typed_in: 1'b0, want: NO_RESULT},
    '{word: 16'h2AAA, typed_in: 1'b0, want: NO_RESULT},
    '{word: 16'h9555, typed_in: 1'b0, want: NO_RESULT},
    '{word: 16'h3000, typed_in: 1'b0, want: NO_RESULT},
    '{word: 16'h0001, typed_in: 1'b0, want: NO_RESULT},
    '{word: 16'h3800, typed_in: 1'b0, want: NO_RESULT},
    '{word: 16'h0400, typed_in: 1'b0, want: NO_RESULT},
    '{word: 16'h6000, typed_in: 1'b0, want: NO_RESULT}
  };

  // DUT inputs start known at time zero.
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = CFG_ANGLE_OFFSET;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  absolute_encoder_angle_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // raw_word
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // raw_angle, joint_angle, rotor_angle, turn_count, extended_position,
    // position_delta, zero pad
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Tracker predictor: own copy of config and state, updated per accepted beat
  // ---------------------------------------------------------------------------
  logic [ANGLE_W-1:0]        trk_offset = '0;
  logic [PP_W-1:0]           trk_poles  = POLE_PAIRS_RST;
  logic [TC_W-1:0]           trk_turns  = '0;
  logic                      trk_prev_a = 1'b0;
  int                        trk_ptr    = 0;
  logic signed [EXT_W-1:0]   pos_history [HISTORY_DEPTH];

  track_t pending_tracks [$];   // expected beats, oldest first
  int     mismatches = 0;

  function automatic track_t track_sample(input logic [IN_TDATA_W-1:0] word);
    track_t                  res;
    logic [ANGLE_W-1:0]      raw;
    logic [ANGLE_W+PP_W-1:0] prod;
    logic                    a;
    logic                    b;
    longint                  pos_l;
    longint                  diff;
    longint                  dmax;
    longint                  dmin;
    raw  = word[ANGLE_W-1:0];
    dmax = longint'(32'sh7FFF_FFFF);
    dmin = -dmax - 1;
    res.raw   = raw;
    res.joint = raw - trk_offset;             // wraps mod one turn
    prod      = res.joint * trk_poles;
    res.rotor = prod[ANGLE_W-1:0];
    // emulated quadrature from the angle bands
    a = (raw < BAND_A_END);
    b = (raw >= BAND_B_START) && (raw < BAND_B_END);
    if (!trk_prev_a && a && !b)
      trk_turns = trk_turns + 1'b1;
    else if (trk_prev_a && !a && !b)
      trk_turns = trk_turns - 1'b1;
    trk_prev_a = a;
    res.turns  = trk_turns;
    pos_l   = longint'($signed(trk_turns)) * 16384 + longint'(raw) - longint'(trk_offset);
    res.pos = pos_l[EXT_W-1:0];
    // delta against the ring entry from HISTORY_DEPTH beats back, saturated
    diff = pos_l - longint'(pos_history[trk_ptr]);
    if (diff > dmax)
      diff = dmax;
    else if (diff < dmin)
      diff = dmin;
    res.delta = diff[DELTA_W-1:0];
    pos_history[trk_ptr] = pos_l[EXT_W-1:0];
    trk_ptr = (trk_ptr == HISTORY_DEPTH - 1) ? 0 : trk_ptr + 1;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic diff_field(input string name, input logic [63:0] want,
                            input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endtask

  task automatic check_track(input track_t got);
    track_t want;
    if (pending_tracks.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("unexpected result beat: %h", got);
    end else begin
      want = pending_tracks.pop_front();
      diff_field("raw_angle",         want.raw,   got.raw);
      diff_field("joint_angle",       want.joint, got.joint);
      diff_field("rotor_angle",       want.rotor, got.rotor);
      diff_field("turn_count",        want.turns, got.turns);
      diff_field("extended_position", want.pos,   got.pos);
      diff_field("position_delta",    want.delta, got.delta);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off requested by toggling
  // hold_req from the stimulus side. The hold-off is counted down here.
  // ---------------------------------------------------------------------------
  int   send_gap_pct   = 8;
  int   recv_stall_pct = 61;
  logic hold_req       = 1'b0;
  logic hold_ack       = 1'b0;
  int   hold_left      = 0;

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      check_track(m_axis_tdata[OUT_FIELDS_W-1:0]);
    if (hold_req != hold_ack) begin
      hold_ack      <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: too long without a beat on either side means a hang.
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("absolute_encoder_angle_tracker test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one sensor word, with an optional idle gap first, and record the
  // expected beat once the handshake completes.
  task automatic offer_word(input logic [IN_TDATA_W-1:0] word, input logic typed_in,
                            input track_t want);
    track_t pred;
    // each idle cycle is drawn on its own, so the sender idles send_gap_pct of the time
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = track_sample(word);   // always run, keeps predictor state in step
    pending_tracks.push_back(typed_in ? want : pred);
  endtask

  // Stop offering and wait for every outstanding result beat.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_tracks.size() != 0) @(posedge clk_i);
  endtask

  // Both registers, written back to back while the pipeline is empty.
  task automatic set_config(input logic [ANGLE_W-1:0] offset, input logic [PP_W-1:0] poles);
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ANGLE_OFFSET;
    cfg_data_i <= offset;
    @(posedge clk_i);
    trk_offset = offset;
    cfg_idx_i  <= CFG_POLE_PAIRS;
    cfg_data_i <= CFG_DATA_W'(poles);
    @(posedge clk_i);
    trk_poles  = poles;
    cfg_we_i   <= 1'b0;
  endtask

  // Random sensor words: mostly coherent rotation runs (direction and maximum
  // step size held for a while, so bands are crossed in order and turns pile up),
  // with some fully random words mixed in as noise.
  logic [ANGLE_W-1:0] walk_angle = '0;
  int                 run_left   = 0;
  int                 run_max    = 1;
  logic               run_fwd    = 1'b1;

  function automatic logic [IN_TDATA_W-1:0] next_sensor_word();
    int step;
    if (run_left == 0) begin
      run_left = $urandom_range(5, 40);
      run_max  = $urandom_range(50, 3000);
      run_fwd  = 1'($urandom_range(0, 1));
    end
    run_left--;
    if ($urandom_range(0, 99) < 15)
      return IN_TDATA_W'($urandom);
    step = $urandom_range(1, run_max);
    walk_angle = run_fwd ? walk_angle + ANGLE_W'(step) : walk_angle - ANGLE_W'(step);
    return {2'($urandom_range(0, 3)), walk_angle};
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [ANGLE_W-1:0] offset;
    logic [PP_W-1:0]    poles;
    foreach (pos_history[i]) pos_history[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed sweep under reset config
    for (int i = 0; i < SWEEP_N; i++)
      offer_word(SWEEP_ROWS[i].word, SWEEP_ROWS[i].typed_in, SWEEP_ROWS[i].want);

    for (int ph = 0; ph < PHASE_N; ph++) begin
      case (ph)
        0: begin
          offset = 14'd16383;
          poles  = 7'd64;
        end
        1: begin            // no pole pairs: rotor angle stays zero
          offset = 14'd0;
          poles  = 7'd0;
        end
        3: begin
          offset = 14'd1;
          poles  = 7'd1;
        end
        5: begin
          offset = 14'd8192;
          poles  = 7'd7;
        end
        default: begin
          offset = ANGLE_W'($urandom_range(0, 16383));
          poles  = PP_W'($urandom_range(1, 64));
        end
      endcase
      set_config(offset, poles);
      // idle pattern: sender light / receiver heavy, then swapped, then none
      if (ph < 2) begin
        send_gap_pct   = 8;
        recv_stall_pct = 61;
      end else if (ph < 4) begin
        send_gap_pct   = 61;
        recv_stall_pct = 8;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 2 && k == 60)
          wait_drained();            // sender pause until all results are back
        if (ph == 4 && k == 40)
          hold_req <= ~hold_req;     // receiver holds off, input backs up
        offer_word(next_sensor_word(), 1'b0, NO_RESULT);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending_tracks.size() == 0) begin
      $display("absolute_encoder_angle_tracker test passed");
    end else begin
      $display("absolute_encoder_angle_tracker test failed");
    end
    $finish;
  end

endmodule
